// File: rtl/core/aabd_pkg.sv
// Shared types and constants of the ASCII art box downscaler.
// Holds the payload structs, the register index codes and the ramp table.
// No dependencies.
`timescale 1ns / 1ps

package aabd_pkg;

  // Fixed widths of registers, fields and state
  localparam int DIM_W        = 13;
  localparam int BLK_W        = 7;
  localparam int BLK_CNT_W    = 6;
  localparam int ROW_W        = 12;
  localparam int CHAR_W       = 7;
  localparam int GRAY_W       = 10;
  localparam int SUM_W        = 22;
  localparam int MAX_BLOCK    = 64;
  localparam int HEIGHT_BOUND = 4096;
  localparam int RAMP_LENGTH  = 70;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [SUM_W-1:0] SUM_CEIL  = 22'h3FFFFF;
  localparam logic [9:0]       GRAY_SPAN = 10'd765;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_BLOCK_WIDTH  = 2'd2,
    CFG_BLOCK_HEIGHT = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_line;
    logic              end_of_frame;
  } result_t;

  // One finished block on its way to the divider
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [BLK_W-1:0] bw;
    logic [BLK_W-1:0] bh;
    logic             eol;
    logic             eof;
  } job_t;

  typedef struct packed {
    logic empty;
    logic afull;
  } queue_status_t;

  // Brightness ramp, dark to light, first character in the top byte
  localparam logic [8*RAMP_LENGTH-1:0] RAMP_CHARS =
    {"$@B%8&WM#*oahkbdpqwmZO0QLCJUYXzcvunxrjft/\\|()1{}[]?-_+~<>i!lI;:,\"^",
     8'h60, "'. "};

  // Map a ramp index onto its character, clamping past the last entry
  function automatic logic [CHAR_W-1:0] ramp_char(input logic [6:0] idx);
    logic [6:0] pos;
    pos = (idx > 7'(RAMP_LENGTH - 1)) ? 7'(RAMP_LENGTH - 1) : idx;
    return RAMP_CHARS[8*(RAMP_LENGTH - 1 - int'(pos)) +: CHAR_W];
  endfunction

endpackage

// File: rtl/core/aabd_front.sv
// Front end: configuration registers, raster counters and block sum memory.
// Accepts pixels and pushes finished blocks as jobs. Depends on aabd_pkg.
`timescale 1ns / 1ps

module aabd_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  aabd_pkg::cfg_index_t       cfg_index,
  input  logic [aabd_pkg::DIM_W-1:0] cfg_data,
  input  logic                       in_push,
  input  aabd_pkg::pixel_t           in_pixel,
  output logic                       in_full,
  input  aabd_pkg::queue_status_t    q_status,
  output logic                       q_push,
  output aabd_pkg::job_t             q_job
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic [aabd_pkg::DIM_W-1:0] img_w_r, img_h_r;
  logic [aabd_pkg::BLK_W-1:0] blk_w_r, blk_h_r;

  logic [COL_W-1:0]               col_r, col_nxt, bcol_r, bcol_nxt;
  logic [aabd_pkg::ROW_W-1:0]     row_r, row_nxt;
  logic [aabd_pkg::BLK_CNT_W-1:0] cib_r, cib_nxt, rib_r, rib_nxt;

  logic [COL_W-1:0]               wm1;
  logic [aabd_pkg::ROW_W-1:0]     hm1;
  logic [aabd_pkg::BLK_CNT_W-1:0] bwm1, bhm1;

  logic                        accept, row_end, frame_end, last_col, last_row;
  logic [aabd_pkg::GRAY_W-1:0] gray;

  logic                        s1_valid_r, s1_first_r, s1_emit_r, s1_eol_r, s1_eof_r;
  logic [aabd_pkg::GRAY_W-1:0] s1_gray_r;
  logic [COL_W-1:0]            s1_slot_r;

  logic [aabd_pkg::SUM_W-1:0] sums_mem [MAX_WIDTH];
  logic [aabd_pkg::SUM_W-1:0] rd_r, acc;
  logic [aabd_pkg::SUM_W:0]   acc_wide;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= aabd_pkg::DIM_W'(1);
      img_h_r <= aabd_pkg::DIM_W'(1);
      blk_w_r <= aabd_pkg::BLK_W'(1);
      blk_h_r <= aabd_pkg::BLK_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        aabd_pkg::CFG_IMAGE_WIDTH:  img_w_r <= cfg_data;
        aabd_pkg::CFG_IMAGE_HEIGHT: img_h_r <= cfg_data;
        aabd_pkg::CFG_BLOCK_WIDTH:  blk_w_r <= cfg_data[aabd_pkg::BLK_W-1:0];
        aabd_pkg::CFG_BLOCK_HEIGHT: blk_h_r <= cfg_data[aabd_pkg::BLK_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the sizes and form the last positions
  always_comb begin
    if (img_w_r == '0) wm1 = '0;
    else if (32'(img_w_r) > MAX_WIDTH) wm1 = COL_W'(MAX_WIDTH - 1);
    else wm1 = COL_W'(img_w_r - aabd_pkg::DIM_W'(1));

    if (img_h_r == '0) hm1 = '0;
    else if (32'(img_h_r) > aabd_pkg::HEIGHT_BOUND) hm1 = aabd_pkg::ROW_W'(aabd_pkg::HEIGHT_BOUND - 1);
    else hm1 = aabd_pkg::ROW_W'(img_h_r - aabd_pkg::DIM_W'(1));

    if (blk_w_r == '0) bwm1 = '0;
    else if (32'(blk_w_r) > aabd_pkg::MAX_BLOCK) bwm1 = aabd_pkg::BLK_CNT_W'(aabd_pkg::MAX_BLOCK - 1);
    else bwm1 = aabd_pkg::BLK_CNT_W'(blk_w_r - aabd_pkg::BLK_W'(1));

    if (blk_h_r == '0) bhm1 = '0;
    else if (32'(blk_h_r) > aabd_pkg::MAX_BLOCK) bhm1 = aabd_pkg::BLK_CNT_W'(aabd_pkg::MAX_BLOCK - 1);
    else bhm1 = aabd_pkg::BLK_CNT_W'(blk_h_r - aabd_pkg::BLK_W'(1));
  end

  // Classify the incoming pixel
  assign in_full   = q_status.afull;
  assign accept    = in_push && !in_full;
  assign gray      = aabd_pkg::GRAY_W'(in_pixel.red) + aabd_pkg::GRAY_W'(in_pixel.green)
                   + aabd_pkg::GRAY_W'(in_pixel.blue);
  assign row_end   = (col_r >= wm1);
  assign frame_end = (row_r >= hm1);
  assign last_col  = (cib_r >= bwm1) || row_end;
  assign last_row  = (rib_r >= bhm1) || frame_end;

  // Advance the raster counters
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    cib_nxt  = cib_r;
    rib_nxt  = rib_r;
    bcol_nxt = bcol_r;
    if (row_end) begin
      col_nxt  = '0;
      cib_nxt  = '0;
      bcol_nxt = '0;
      if (frame_end) begin
        row_nxt = '0;
        rib_nxt = '0;
      end else begin
        row_nxt = row_r + aabd_pkg::ROW_W'(1);
        rib_nxt = (rib_r >= bhm1) ? '0 : rib_r + aabd_pkg::BLK_CNT_W'(1);
      end
    end else begin
      col_nxt = col_r + COL_W'(1);
      if (cib_r >= bwm1) begin
        cib_nxt  = '0;
        bcol_nxt = bcol_r + COL_W'(1);
      end else begin
        cib_nxt = cib_r + aabd_pkg::BLK_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      cib_r      <= '0;
      rib_r      <= '0;
      bcol_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        cib_r  <= cib_nxt;
        rib_r  <= rib_nxt;
        bcol_r <= bcol_nxt;
      end
    end
  end

  // Hold the accepted pixel for the update stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_first_r <= (cib_r == '0) && (rib_r == '0);
      s1_gray_r  <= gray;
      s1_slot_r  <= bcol_r;
      s1_emit_r  <= last_col && last_row;
      s1_eol_r   <= row_end;
      s1_eof_r   <= row_end && frame_end;
    end
  end

  // Add the pixel to the running sum, saturating; a block's first pixel starts it anew
  assign acc_wide = {1'b0, rd_r} + (aabd_pkg::SUM_W + 1)'(s1_gray_r);
  always_comb begin
    if (s1_first_r) acc = aabd_pkg::SUM_W'(s1_gray_r);
    else if (acc_wide[aabd_pkg::SUM_W]) acc = aabd_pkg::SUM_CEIL;
    else acc = acc_wide[aabd_pkg::SUM_W-1:0];
  end

  // Write back the sum; forward it when the next pixel reads the same slot
  always_ff @(posedge clk) begin
    if (s1_valid_r) sums_mem[s1_slot_r] <= acc;
    if (accept) begin
      if (s1_valid_r && (s1_slot_r == bcol_r)) rd_r <= acc;
      else rd_r <= sums_mem[bcol_r];
    end
  end

  // Push a finished block
  assign q_push    = s1_valid_r && s1_emit_r;
  assign q_job.sum = acc;
  assign q_job.bw  = aabd_pkg::BLK_W'(bwm1) + aabd_pkg::BLK_W'(1);
  assign q_job.bh  = aabd_pkg::BLK_W'(bhm1) + aabd_pkg::BLK_W'(1);
  assign q_job.eol = s1_eol_r;
  assign q_job.eof = s1_eof_r;

endmodule

// File: rtl/core/aabd_queue.sv
// Short job queue between the front end and the divider back end.
// Flags almost full one entry early to cover the job in flight. Depends on aabd_pkg.
`timescale 1ns / 1ps

module aabd_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  aabd_pkg::job_t          push_job,
  input  logic                    pop,
  output aabd_pkg::job_t          head_job,
  output aabd_pkg::queue_status_t status
);

  localparam int PTR_W = $clog2(aabd_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(aabd_pkg::QUEUE_DEPTH + 1);

  aabd_pkg::job_t   slots_r [aabd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_job;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(aabd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_r + PTR_W'(1);
      if (pop) rd_ptr_r <= (rd_ptr_r == PTR_W'(aabd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_r + PTR_W'(1);
      unique case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign head_job     = slots_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.afull = (count_r >= CNT_W'(aabd_pkg::QUEUE_DEPTH - 1));

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(aabd_pkg::QUEUE_DEPTH))
    else $error("job queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_W'(aabd_pkg::QUEUE_DEPTH)) |-> (!push || pop))
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("job popped from an empty queue");
`endif

endmodule

// File: rtl/core/aabd_back.sv
// Back end: scales a block sum, divides by the block area with a restoring
// divider one quotient bit a cycle, maps onto the ramp and holds the result.
// Depends on aabd_pkg.
`timescale 1ns / 1ps

module aabd_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  aabd_pkg::job_t          q_head,
  input  aabd_pkg::queue_status_t q_status,
  output logic                    q_pop,
  input  logic                    out_pop,
  output logic                    out_empty,
  output aabd_pkg::result_t       out_result
);

  localparam int NUM_W  = aabd_pkg::SUM_W + 7;
  localparam int AREA_W = 2 * aabd_pkg::BLK_W - 1;
  localparam int DEN_W  = AREA_W + 10;
  localparam int REM_W  = DEN_W + 7;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEN  = 4'b0010,
    S_DIV  = 4'b0100,
    S_HOLD = 4'b1000
  } back_state_t;

  back_state_t       state_r;
  logic [NUM_W-1:0]  num_r;
  logic [AREA_W-1:0] area_r;
  logic [REM_W-1:0]  rem_r, dsh_r;
  logic [7:0]        quo_r;
  logic [2:0]        step_r;
  logic              eol_r, eof_r;
  logic              out_valid_r, load;
  aabd_pkg::result_t out_res_r;
  logic [6:0]        pos;

  assign q_pop = (state_r == S_IDLE) && !q_status.empty;
  assign load  = (state_r == S_HOLD) && (!out_valid_r || out_pop);
  assign pos   = quo_r[7] ? 7'(aabd_pkg::RAMP_LENGTH - 1) : quo_r[6:0];

  // Sequence one job through scale, divisor and divide steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (q_pop) state_r <= S_DEN;
        S_DEN:  state_r <= S_DIV;
        S_DIV:  if (step_r == '0) state_r <= S_HOLD;
        S_HOLD: if (load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath of the divider
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        num_r  <= NUM_W'(q_head.sum) * NUM_W'(aabd_pkg::RAMP_LENGTH);
        area_r <= AREA_W'(q_head.bw) * AREA_W'(q_head.bh);
        eol_r  <= q_head.eol;
        eof_r  <= q_head.eof;
      end
      S_DEN: begin
        dsh_r  <= {DEN_W'(area_r) * DEN_W'(aabd_pkg::GRAY_SPAN), 7'b0};
        rem_r  <= REM_W'(num_r);
        quo_r  <= '0;
        step_r <= 3'd7;
      end
      S_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          quo_r <= {quo_r[6:0], 1'b1};
        end else begin
          quo_r <= {quo_r[6:0], 1'b0};
        end
        dsh_r  <= dsh_r >> 1;
        step_r <= step_r - 3'd1;
      end
      S_HOLD: ;
      default: ;
    endcase
  end

  // Output register, freed by a pop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && !out_pop) || load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r.char_code    <= aabd_pkg::ramp_char(pos);
      out_res_r.end_of_line  <= eol_r;
      out_res_r.end_of_frame <= eof_r;
    end
  end

  assign out_empty  = !out_valid_r;
  assign out_result = out_res_r;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_pop))
    else $error("result overwritten before it was taken");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_DEN))
    else $error("divider did not start after taking a job");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_result)))
    else $error("waiting result changed before it was taken");
`endif

endmodule

// File: rtl/core/ascii_art_box_downscaler.sv
// Top level of the ASCII art box downscaler.
// Ties the front end, the job queue and the divider back end. Depends on aabd_pkg.
`timescale 1ns / 1ps

// Pixels go in as RGB in raster order, one item per cycle at most while in_full
// is low; the gray value of each block of block_width by block_height pixels
// is averaged over the full block area and comes out as one character of a
// 70-step ramp from dark to light, with end_of_line and end_of_frame flags.
// The front end takes one pixel a cycle unless in_full holds it: it reads the
// block column's running sum from a MAX_WIDTH-entry memory and writes it back
// the next cycle, with forwarding. Each character then passes through the
// back end (scale, divisor, eight restoring divide steps, hand-off), which
// takes no new job until the last character is handed off; a four-entry job
// queue absorbs bursts, and in_full holds pixels while it is almost full. The
// sum memory needs no clearing pass: every block's first pixel overwrites its
// slot. Write the size registers only while idle.
module ascii_art_box_downscaler #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  aabd_pkg::cfg_index_t       cfg_index,
  input  logic [aabd_pkg::DIM_W-1:0] cfg_data,
  input  logic                       in_push,
  input  aabd_pkg::pixel_t           in_pixel,
  output logic                       in_full,
  input  logic                       out_pop,
  output logic                       out_empty,
  output aabd_pkg::result_t          out_result
);

  logic                    q_push, q_pop;
  aabd_pkg::job_t          q_job, q_head;
  aabd_pkg::queue_status_t q_status;

  // Accept and classify pixels
  aabd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_pixel  (in_pixel),
    .in_full   (in_full),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // Buffer finished blocks
  aabd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head_job (q_head),
    .status   (q_status)
  );

  // Divide and map onto the ramp
  aabd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_status   (q_status),
    .q_pop      (q_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_result (out_result)
  );

endmodule
